// ===== rtl/rrf_pkg.sv =====
// Package with shared types and constants for the reply framer.
`default_nettype none
package rrf_pkg;
	localparam int NEST_DEPTH = 8;
	localparam int LEN_BITS = 32;
	localparam int LVL_W = $clog2(NEST_DEPTH + 1);
	localparam int IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	localparam int QDEPTH = 2;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2a;

	typedef enum logic [2:0] {
		PH_TYPE = 3'd0,
		PH_WS = 3'd1,
		PH_SIGN = 3'd2,
		PH_DIGITS = 3'd3,
		PH_REST = 3'd4,
		PH_BULK = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_BULK = 2'd1,
		KIND_ARRAY = 2'd2
	} kind_t;

	// Classification of one byte by the front part.
	typedef struct packed {
		logic [7:0] data;
		logic is_digit;
		logic [3:0] digit;
		logic is_space;
		logic is_cr;
		logic is_lf;
		logic is_sign;
		logic is_minus;
		logic is_dollar;
		logic is_star;
	} cls_t;
endpackage
`default_nettype wire

// ===== rtl/resp_reply_framer_top.sv =====
// Top level of the reply framer: byte queue front end and parser back end.
// Usage: feed one reply byte per transfer on the in_byte channel (in_valid,
// in_ready). Every byte comes back unchanged on the result channel
// (out_valid, out_ready) with reply_last set on the byte that closes a whole
// top-level reply, parse_error set on a byte that found a bad header number
// or a nesting overflow, and nest_level giving the open array levels.
// From input transfer to result transfer, the byte passes through the
// two-entry byte queue, then the parser step loads the output register.
// Throughput is one byte per cycle while the receiver takes results, set
// by the single parser step per byte; nested array closes are finished
// within that step.
// When the receiver stalls, the output register holds and the parser
// stops; the queue then fills its two entries before in_ready drops.
// After reset the parser waits for a type byte with an empty nesting stack;
// stack entries are written before they are read. After an error the
// parser returns to that same state.
`default_nettype none
module resp_reply_framer_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [7:0] in_byte,
	input wire logic in_valid,
	output logic in_ready,
	output logic [7:0] byte_out,
	output logic reply_last,
	output logic parse_error,
	output logic [3:0] nest_level,
	output logic out_valid,
	input wire logic out_ready
);
	import rrf_pkg::*;

	cls_t q_item;
	logic q_valid, q_ready;

	rrf_front u_front (
		.clk(clk), .arst_n(arst_n), .in_byte(in_byte), .in_valid(in_valid),
		.in_ready(in_ready), .q_item(q_item), .q_valid(q_valid), .q_ready(q_ready)
	);

	rrf_back u_back (
		.clk(clk), .arst_n(arst_n), .q_item(q_item), .q_valid(q_valid),
		.q_ready(q_ready), .byte_out(byte_out), .reply_last(reply_last),
		.parse_error(parse_error), .nest_level(nest_level),
		.out_valid(out_valid), .out_ready(out_ready)
	);

	// An error result always reports an empty stack and no reply end.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_error |-> !reply_last && nest_level == 4'd0)
		else $error("error result with reply end or open levels");

	// A reply end is only reported at the top level.
	a_last_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_last |-> nest_level == 4'd0)
		else $error("reply end with open levels");

	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(reply_last))
		else $error("stalled result changed");
endmodule
`default_nettype wire

// ===== rtl/rrf_front.sv =====
// Front part: accepts bytes, classifies them and queues them for the parser.
`default_nettype none
module rrf_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [7:0] in_byte,
	input wire logic in_valid,
	output logic in_ready,
	output rrf_pkg::cls_t q_item,
	output logic q_valid,
	input wire logic q_ready
);
	import rrf_pkg::*;

	cls_t mem_q [QDEPTH];
	logic [0:0] wr_q, rd_q;
	logic [1:0] cnt_q;
	cls_t c;
	logic push, pop;

	always_comb begin
		c.data = in_byte;
		c.is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
		c.digit = in_byte[3:0];
		c.is_space = (in_byte == 8'h20) || ((in_byte >= 8'h09) && (in_byte <= 8'h0d));
		c.is_cr = in_byte == CH_CR;
		c.is_lf = in_byte == CH_LF;
		c.is_sign = (in_byte == CH_PLUS) || (in_byte == CH_MINUS);
		c.is_minus = in_byte == CH_MINUS;
		c.is_dollar = in_byte == CH_DOLLAR;
		c.is_star = in_byte == CH_STAR;
	end

	assign in_ready = cnt_q != 2'(QDEPTH);
	assign q_valid = cnt_q != 2'd0;
	assign q_item = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/rrf_back.sv =====
// Back part: header, bulk and nesting parser with a registered output stage.
`default_nettype none
module rrf_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire rrf_pkg::cls_t q_item,
	input wire logic q_valid,
	output logic q_ready,
	output logic [7:0] byte_out,
	output logic reply_last,
	output logic parse_error,
	output logic [3:0] nest_level,
	output logic out_valid,
	input wire logic out_ready
);
	import rrf_pkg::*;

	localparam logic [LEN_BITS:0] POS_LIM = {2'b0, {(LEN_BITS - 1){1'b1}}};
	localparam logic [LEN_BITS:0] CAP = POS_LIM + (LEN_BITS + 1)'(2);

	phase_t phase_q, phase_d;
	kind_t kind_q, kind_d;
	logic [LEN_BITS:0] acc_q, acc_d;
	logic neg_q, neg_d, seen_q, seen_d, cr_q, cr_d;
	logic [LEN_BITS:0] bulk_q, bulk_d;
	logic [LEN_BITS-1:0] stk_q [NEST_DEPTH];
	logic [LVL_W-1:0] lvl_q, lvl_d;
	logic [LVL_W-1:0] pop_lvl;
	logic [IDX_W-1:0] dec_idx;
	logic [LEN_BITS-1:0] dec_val;
	logic push_en, dec_en;
	logic [LEN_BITS+4:0] mul;
	logic take, last_d, err_d, done;

	assign q_ready = !out_valid || out_ready;
	assign take = q_valid && q_ready;
	assign mul = (LEN_BITS + 5)'(acc_q) * (LEN_BITS + 5)'(10)
		+ (LEN_BITS + 5)'(q_item.digit);

	// Level left open when an element finishes: every open level above the
	// highest one that still has more than one element to go is down to one
	// and closes as well, so the result is one above that highest level.
	always_comb begin
		pop_lvl = '0;
		for (int i = 0; i < NEST_DEPTH; i++) begin
			if ((LVL_W'(i) < lvl_q) && (stk_q[i] != LEN_BITS'(1))) pop_lvl = LVL_W'(i + 1);
		end
	end

	assign dec_idx = IDX_W'(pop_lvl - LVL_W'(1));
	assign dec_val = stk_q[dec_idx] - LEN_BITS'(1);

	always_comb begin
		phase_d = phase_q;
		kind_d = kind_q;
		acc_d = acc_q;
		neg_d = neg_q;
		seen_d = seen_q;
		cr_d = cr_q;
		bulk_d = bulk_q;
		lvl_d = lvl_q;
		push_en = 1'b0;
		dec_en = 1'b0;
		last_d = 1'b0;
		err_d = 1'b0;
		done = 1'b0;
		case (phase_q)
			PH_TYPE: begin
				acc_d = '0;
				neg_d = 1'b0;
				seen_d = 1'b0;
				cr_d = q_item.is_cr;
				kind_d = q_item.is_dollar ? KIND_BULK : (q_item.is_star ? KIND_ARRAY : KIND_OTHER);
				phase_d = (q_item.is_dollar || q_item.is_star) ? PH_WS : PH_REST;
			end
			PH_BULK: begin
				if (bulk_q != '0) bulk_d = bulk_q - (LEN_BITS + 1)'(1);
				if (bulk_q <= (LEN_BITS + 1)'(1)) done = 1'b1;
			end
			PH_WS, PH_SIGN, PH_DIGITS, PH_REST: begin
				if (cr_q && q_item.is_lf) begin
					cr_d = 1'b0;
					if (kind_q == KIND_OTHER) begin
						done = 1'b1;
					end else if (!seen_q || acc_q > (POS_LIM + (LEN_BITS + 1)'(neg_q))) begin
						err_d = 1'b1;
					end else if (neg_q && acc_q != '0) begin
						done = 1'b1;
					end else if (kind_q == KIND_BULK) begin
						bulk_d = acc_q + (LEN_BITS + 1)'(2);
						phase_d = PH_BULK;
					end else if (acc_q == '0) begin
						done = 1'b1;
					end else if (lvl_q >= LVL_W'(NEST_DEPTH)) begin
						err_d = 1'b1;
					end else begin
						push_en = 1'b1;
						lvl_d = lvl_q + LVL_W'(1);
						phase_d = PH_TYPE;
					end
				end else begin
					cr_d = q_item.is_cr;
					if ((phase_q == PH_WS && q_item.is_digit)
						|| ((phase_q == PH_SIGN || phase_q == PH_DIGITS) && q_item.is_digit)) begin
						phase_d = PH_DIGITS;
						acc_d = (mul > (LEN_BITS + 5)'(CAP)) ? CAP : (LEN_BITS + 1)'(mul);
						seen_d = 1'b1;
					end else if (phase_q == PH_WS && q_item.is_sign) begin
						neg_d = q_item.is_minus;
						phase_d = PH_SIGN;
					end else if (phase_q == PH_WS) begin
						if (!q_item.is_space) phase_d = PH_REST;
					end else if (phase_q != PH_REST) begin
						phase_d = PH_REST;
					end
				end
			end
			default: err_d = 1'b0;
		endcase
		// Resync on a state code that means nothing.
		if (phase_q > PH_BULK) begin
			phase_d = PH_TYPE;
			kind_d = KIND_OTHER;
			acc_d = '0;
			neg_d = 1'b0;
			seen_d = 1'b0;
			cr_d = 1'b0;
			bulk_d = '0;
			lvl_d = '0;
		end
		// One element finished: all finished levels close in this same byte,
		// and the remaining top level loses one element.
		if (done) begin
			phase_d = PH_TYPE;
			lvl_d = pop_lvl;
			if (pop_lvl == '0) begin
				last_d = 1'b1;
			end else begin
				dec_en = 1'b1;
			end
		end
		if (err_d) begin
			phase_d = PH_TYPE;
			kind_d = KIND_OTHER;
			acc_d = '0;
			neg_d = 1'b0;
			seen_d = 1'b0;
			cr_d = 1'b0;
			bulk_d = '0;
			lvl_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (push_en) stk_q[IDX_W'(lvl_q)] <= acc_q[LEN_BITS-1:0];
			if (dec_en) stk_q[dec_idx] <= dec_val;
			byte_out <= q_item.data;
			reply_last <= last_d;
			parse_error <= err_d;
			nest_level <= (lvl_d > LVL_W'(15)) ? 4'd15 : 4'(lvl_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			kind_q <= KIND_OTHER;
			acc_q <= '0;
			neg_q <= 1'b0;
			seen_q <= 1'b0;
			cr_q <= 1'b0;
			bulk_q <= '0;
			lvl_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				kind_q <= kind_d;
				acc_q <= acc_d;
				neg_q <= neg_d;
				seen_q <= seen_d;
				cr_q <= cr_d;
				bulk_q <= bulk_d;
				lvl_q <= lvl_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the reply framer: random and directed reply streams checked against a predictor.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rrf_pkg::*;

	// One result of the framer as the predictor sees it.
	typedef struct {
		logic [7:0] b;
		logic last;
		logic err;
		logic [3:0] lvl;
	} frame_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] byte_out;
	logic reply_last;
	logic parse_error;
	logic [3:0] nest_level;
	logic out_valid;
	logic out_ready = 1'b0;

	resp_reply_framer_top DUT (
		.clk(clk), .arst_n(arst_n), .in_byte(in_byte), .in_valid(in_valid),
		.in_ready(in_ready), .byte_out(byte_out), .reply_last(reply_last),
		.parse_error(parse_error), .nest_level(nest_level), .out_valid(out_valid),
		.out_ready(out_ready)
	);

	always #2 clk = ~clk;

	// Predictor state, a private copy of the parser registers.
	phase_t p_phase;
	kind_t p_kind;
	logic [31:0] p_acc;
	logic p_neg, p_seen, p_cr;
	logic [31:0] p_bulk;
	logic [31:0] p_stack [NEST_DEPTH];
	int p_lvl;

	logic [7:0] byte_q[$];        // bytes waiting to be driven
	frame_res_t framed_q[$];      // expected results in order
	int fail_cnt = 0;
	int n_bytes = 0;               // bytes queued so far
	bit hold_send = 1'b0;          // sender holds off while set
	bit calm = 1'b0;               // no idling on either side while set

	// The handshake as seen at the last rising edge.
	logic in_ready_s = 1'b0;
	always @(posedge clk) in_ready_s <= in_ready;

	function automatic void parser_resync();
		p_phase = PH_TYPE; p_kind = KIND_OTHER; p_acc = 0; p_neg = 0; p_seen = 0;
		p_cr = 0; p_bulk = 0; p_lvl = 0;
	endfunction

	// Closes one element; returns 1 when the whole top-level reply is done.
	function automatic bit close_element();
		p_phase = PH_TYPE;
		while (p_lvl > 0) begin
			p_stack[p_lvl-1] = p_stack[p_lvl-1] - 1;
			if (p_stack[p_lvl-1] != 0) return 1'b0;
			p_lvl--;
		end
		return 1'b1;
	endfunction

	function automatic void header_char(logic [7:0] b);
		bit dig;
		bit sp;
		logic [35:0] v;
		dig = (b >= "0" && b <= "9");
		sp = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
		case (p_phase)
			PH_WS: begin
				if (!dig) begin
					if (b == CH_PLUS || b == CH_MINUS) begin
						p_neg = (b == CH_MINUS);
						p_phase = PH_SIGN;
					end else if (!sp) p_phase = PH_REST;
					return;
				end
				p_phase = PH_DIGITS;
			end
			PH_SIGN: begin
				if (!dig) begin
					p_phase = PH_REST;
					return;
				end
				p_phase = PH_DIGITS;
			end
			PH_DIGITS: if (!dig) begin
				p_phase = PH_REST;
				return;
			end
			default: return;
		endcase
		// Saturate just above the largest legal magnitude so range errors stick.
		v = p_acc * 36'd10 + (b - "0");
		if (v > 36'h80000001) v = 36'h80000001;
		p_acc = v[31:0];
		p_seen = 1'b1;
	endfunction

	// Returns 0 nothing, 1 reply done, 2 error.
	function automatic int header_end();
		logic [32:0] lim;
		p_cr = 1'b0;
		if (p_kind == KIND_OTHER) return close_element() ? 1 : 0;
		lim = 33'h7fffffff + (p_neg ? 1 : 0);
		if (!p_seen || {1'b0, p_acc} > lim) return 2;
		if (p_neg && p_acc != 0) return close_element() ? 1 : 0;
		if (p_kind == KIND_BULK) begin
			p_bulk = p_acc + 2;
			p_phase = PH_BULK;
			return 0;
		end
		if (p_acc == 0) return close_element() ? 1 : 0;
		if (p_lvl >= NEST_DEPTH) return 2;
		p_stack[p_lvl] = p_acc;
		p_lvl++;
		p_phase = PH_TYPE;
		return 0;
	endfunction

	function automatic frame_res_t frame_byte(logic [7:0] b);
		frame_res_t r;
		int res;
		res = 0;
		if (p_phase == PH_TYPE) begin
			p_acc = 0; p_neg = 0; p_seen = 0;
			p_cr = (b == CH_CR);
			p_kind = (b == CH_DOLLAR) ? KIND_BULK : (b == CH_STAR) ? KIND_ARRAY : KIND_OTHER;
			p_phase = (p_kind == KIND_OTHER) ? PH_REST : PH_WS;
		end else if (p_phase == PH_BULK) begin
			if (p_bulk > 0) p_bulk--;
			if (p_bulk == 0) res = close_element() ? 1 : 0;
		end else if (p_cr && b == CH_LF) begin
			res = header_end();
		end else begin
			p_cr = (b == CH_CR);
			header_char(b);
		end
		if (res == 2) parser_resync();
		r.b = b;
		r.last = (res == 1);
		r.err = (res == 2);
		r.lvl = p_lvl[3:0];
		return r;
	endfunction

	// Driver: one transfer per accepted byte, updated at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_s) begin
				if (byte_q.size() > 0 && !hold_send && (calm || $urandom_range(99) >= 22)) begin
					in_byte <= byte_q[0];
					framed_q.insert(framed_q.size(), frame_byte(byte_q.pop_front()));
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= calm || ($urandom_range(99) >= 22);
		end
	end

	// Monitor: compares every result transfer with the oldest expectation.
	always @(posedge clk) begin
		frame_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (framed_q.size() == 0) begin
				$display("%0t: unexpected result byte %02h", $time, byte_out);
				fail_cnt++;
			end else begin
				e = framed_q.pop_front();
				if (byte_out !== e.b || reply_last !== e.last || parse_error !== e.err
					|| nest_level !== e.lvl) begin
					$display("%0t: mismatch expected b=%02h last=%0d err=%0d lvl=%0d",
						$time, e.b, e.last, e.err, e.lvl);
					$display("%0t:          actual   b=%02h last=%0d err=%0d lvl=%0d",
						$time, byte_out, reply_last, parse_error, nest_level);
					fail_cnt++;
				end
			end
		end
	end

	task automatic put_byte(logic [7:0] v);
		byte_q.insert(byte_q.size(), v);
		n_bytes++;
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	// Builds one random element; depth keeps arrays from growing without end.
	task automatic add_element(int depth);
		int k;
		int n;
		k = $urandom_range(99);
		if (k < 30) begin
			add_str((k % 3 == 0) ? "+" : (k % 3 == 1) ? "-" : ":");
			n = $urandom_range(4);
			repeat (n) put_byte(8'($urandom_range(32, 126)));
			add_str("\r\n");
		end else if (k < 60 || depth >= 10) begin
			n = $urandom_range(9) == 0 ? -1 : $urandom_range(6);
			add_str($sformatf("$%0d\r\n", n));
			if (n >= 0) begin
				repeat (n) put_byte(8'($urandom_range(255)));
				add_str("\r\n");
			end
		end else begin
			n = $urandom_range(8) == 0 ? -1 : $urandom_range(3);
			add_str($sformatf("*%0d\r\n", n));
			repeat (n < 0 ? 0 : n) add_element(depth + 1);
		end
	endtask

	task automatic wait_drained();
		while (byte_q.size() > 0 || framed_q.size() > 0 || in_valid) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int elem_cnt;
		elem_cnt = 0;
		parser_resync();
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		// Directed: extremes, signs, whitespace, null, empty, bad numbers, overflow.
		add_str("+OK\r\n-ERR x\r\n:-5\r\n");
		add_str("$ +2junk\r\nab\r\n$-1\r\n$0\r\n\r\n*0\r\n*-0\r\n+\r\n");
		add_str("$2147483647x\r\n$2147483648\r\n*-2147483648\r\n$-2147483649\r\n");
		add_str("$\r\n*+\r\n\r\n~q\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n*1\r\n");
		put_byte(8'hff); put_byte(8'h00); add_str("\r\n");
		add_str("*2\r\n*1\r\n*1\r\n:7\r\n$0\r\n\r\n");
		wait_drained();
		// Start a reply, then pause the sender until everything has come back.
		add_str("*2\r\n:1\r\n$1\r\nz\r\n");
		repeat (6) @(posedge clk);
		hold_send = 1'b1;
		while (framed_q.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
		hold_send = 1'b0;
		wait_drained();
		// Random replies, mostly well formed, with noise bytes mixed in.
		while (n_bytes < 1550) begin
			if (elem_cnt == 40) calm = 1'b1;
			if (elem_cnt == 90) calm = 1'b0;
			if ($urandom_range(9) == 0) repeat ($urandom_range(1, 6))
				put_byte(8'($urandom_range(255)));
			else add_element(0);
			elem_cnt++;
			while (byte_q.size() > 32) @(posedge clk);
		end
		wait_drained();
		if (fail_cnt == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== resp_reply_framer_top.f =====
rtl/rrf_pkg.sv
rtl/rrf_front.sv
rtl/rrf_back.sv
rtl/resp_reply_framer_top.sv
verif/tb.sv
